// File: hw/rtl/msgs_pkg.sv
// Shared types and constants for the mutation-selection generation step.
// No dependencies; imported by the top level, the divider and the checker.
`timescale 1ns / 1ps
package msgs_pkg;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_MUT   = 3'd1;
    localparam logic [2:0] OP_FIT   = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [1:0] KIND_BIN   = 2'd0;
    localparam logic [1:0] KIND_TOTAL = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic [2:0] REG_KERNEL_LEN = 3'd0;
    localparam logic [2:0] REG_PROB_ONE   = 3'd1;
    localparam logic [2:0] REG_PROB_TWO   = 3'd2;
    localparam logic [2:0] REG_PROB_THREE = 3'd3;
    localparam logic [2:0] REG_PROB_FOUR  = 3'd4;
    localparam logic [2:0] REG_PROB_FIVE  = 3'd5;
    localparam logic [2:0] REG_FITNESS    = 3'd6;

    localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
    localparam logic [31:0] FITNESS_RST = 32'd214748365;
    localparam logic [40:0] RES_MAX     = 41'h1FF_FFFF_FFFF;

    // Request from the sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [32:0] y;
    } div_req_t;

endpackage

// File: hw/rtl/mutation_selection_generation_step.sv
// Mutation-selection generation step: the histogram store and its op sequencer.
// Depends on msgs_pkg and msgs_div.
//
// Use: pulse start with op, bin_index and bin_value while busy is low; the
// request is taken at that edge. Registers are written on the cfg channel
// (cfg_index, cfg_data) whenever cfg_valid is high; cfg_ready is always high.
// Write them only while busy is low and no request is in flight.
// Results appear for one cycle with result_valid high and cannot be held off.
// Sequence of states for each op:
//   write bin: busy stays low, no result.
//   read bin: the word is registered out of the store, then the result.
//   mean load: ISSUE, FETCH and LOAD_ACC for each bin in turn.
//   mutation step: ISSUE, FETCH, MUT_MUL/MUT_ACC per spread tap, then MUT_WR.
//   fitness step: ISSUE, FETCH and FIT_ACC per bin for the total, then a
//   second pass through the bit-serial divider, which sets the pace of this op.
// After reset the block walks the store, setting bin 0 to one and the rest
// to zero; busy is high meanwhile.
`timescale 1ns / 1ps
module mutation_selection_generation_step #(
    parameter int BINS       = 1024,
    parameter int KERNEL_MAX = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [9:0]  bin_index,
    input  logic [31:0] bin_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [40:0] result_value,
    output logic        divide_fault
);
    import msgs_pkg::*;

    localparam int AW   = $clog2(BINS);
    localparam int JW   = $clog2(KERNEL_MAX);
    localparam int LIMW = AW + 5;
    localparam int PW   = 33 + $clog2(KERNEL_MAX);
    localparam int TW   = 33 + AW;
    localparam int LW   = 32 + 2 * AW;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_ISSUE, ST_FETCH, ST_MUT_MUL, ST_MUT_ACC,
        ST_MUT_WR, ST_FIT_ACC, ST_DIV, ST_LOAD_ACC
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   i_reg;
    logic [2:0]      op_reg;
    logic            in_range_reg;
    logic            pass_reg;
    logic [JW-1:0]   j_reg;
    logic [31:0]     old_reg;
    logic [63:0]     prod_reg;
    logic [63:0]     wprod_reg;
    logic [31:0]     w_reg;
    logic [TW-1:0]   total_reg;
    logic [LW-1:0]   acc_reg;
    logic [PW-1:0]   out_sum_reg;
    logic [PW-1:0]   pend_reg [KERNEL_MAX];
    div_req_t        div_req_reg;

    logic [2:0]      kernel_length_reg;
    logic [31:0]     mut_prob_reg [5];
    logic [31:0]     fitness_factor_reg;

    logic            result_valid_reg;
    logic [1:0]      result_kind_reg;
    logic [40:0]     result_value_reg;
    logic            divide_fault_reg;

    logic [31:0]     mem [BINS];
    logic [31:0]     rd_data_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [31:0]     mem_wdata;

    logic [AW-1:0]   bin_addr;
    logic            bin_in_range;
    logic            last_bin;
    logic [LIMW-1:0] k_sat;
    logic [LIMW-1:0] room;
    logic [LIMW-1:0] lim;
    logic [31:0]     prob_sel;
    logic [32:0]     amount;
    logic [PW+1:0]   mut_sum;
    logic [31:0]     mut_new;
    logic [TW-1:0]   total_next;
    logic [31:0]     w_next;
    logic [AW+31:0]  load_prod;
    logic            div_done;
    logic [31:0]     div_q;

    assign bin_addr     = AW'(bin_index);
    assign bin_in_range = 32'(bin_index) < 32'(BINS);
    assign last_bin     = i_reg == AW'(BINS - 1);

    assign k_sat = (LIMW'(kernel_length_reg) > LIMW'(KERNEL_MAX)) ?
                   LIMW'(KERNEL_MAX) : LIMW'(kernel_length_reg);
    assign room  = LIMW'(BINS - 1) - LIMW'(i_reg);
    assign lim   = (k_sat < room) ? k_sat : room;

    always_comb
    begin
        prob_sel = '0;
        for (int n = 1; n <= 5; n++)
        begin
            if (5'(j_reg) == 5'(n))
                prob_sel = mut_prob_reg[n-1];
        end
    end

    assign amount = prod_reg[63:31];

    // Old value plus arrivals minus departures, then clamp to the word range
    assign mut_sum = {2'b00, PW'(old_reg)} + {2'b00, pend_reg[0]} - {2'b00, out_sum_reg};
    always_comb
    begin
        if (mut_sum[PW+1])
            mut_new = '0;
        else if (mut_sum[PW:32] != '0)
            mut_new = 32'hFFFF_FFFF;
        else
            mut_new = mut_sum[31:0];
    end

    assign total_next = total_reg + TW'(prod_reg[63:31]);
    assign w_next     = wprod_reg[63] ? 32'hFFFF_FFFF : wprod_reg[62:31];
    assign load_prod  = (AW+32)'(i_reg) * (AW+32)'(rd_data_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_reg;
        mem_wdata = mut_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (i_reg == '0) ? ONE_Q31 : '0;
            end
            ST_IDLE:
            begin
                mem_we    = start && op == OP_WRITE && bin_in_range;
                mem_waddr = bin_addr;
                mem_wdata = bin_value;
            end
            ST_MUT_WR:
                mem_we = 1'b1;
            ST_DIV:
            begin
                mem_we    = div_done;
                mem_wdata = div_q;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    assign mem_raddr = (state_reg == ST_IDLE) ? bin_addr : i_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    msgs_div #(
        .TW(TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            i_reg              <= '0;
            kernel_length_reg  <= 3'd1;
            mut_prob_reg       <= '{default: '0};
            fitness_factor_reg <= FITNESS_RST;
            result_valid_reg   <= 1'b0;
            div_req_reg        <= '0;
        end
        else
        begin
            result_valid_reg  <= 1'b0;
            div_req_reg.start <= 1'b0;

            if (cfg_valid)
            begin
                if (cfg_index == REG_KERNEL_LEN)
                    kernel_length_reg <= cfg_data[2:0];
                else if (cfg_index >= REG_PROB_ONE && cfg_index <= REG_PROB_FIVE)
                    mut_prob_reg[cfg_index - REG_PROB_ONE] <= cfg_data;
                else if (cfg_index == REG_FITNESS)
                    fitness_factor_reg <= cfg_data;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    i_reg <= i_reg + AW'(1);
                    if (last_bin)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op;
                        in_range_reg <= bin_in_range;
                        i_reg        <= '0;
                        pass_reg     <= 1'b0;
                        w_reg        <= ONE_Q31;
                        total_reg    <= '0;
                        acc_reg      <= '0;
                        pend_reg     <= '{default: '0};
                        if (op == OP_READ)
                            state_reg <= ST_READ;
                        else if (op == OP_MUT || op == OP_FIT || op == OP_LOAD)
                            state_reg <= ST_ISSUE;
                    end
                end
                ST_READ:
                begin
                    result_valid_reg <= 1'b1;
                    result_kind_reg  <= KIND_BIN;
                    result_value_reg <= in_range_reg ? 41'(rd_data_reg) : '0;
                    divide_fault_reg <= 1'b0;
                    state_reg        <= ST_IDLE;
                end
                ST_ISSUE:
                    state_reg <= ST_FETCH;
                ST_FETCH:
                begin
                    old_reg     <= rd_data_reg;
                    out_sum_reg <= '0;
                    j_reg       <= JW'(1);
                    if (op_reg == OP_MUT)
                        state_reg <= (lim > LIMW'(1)) ? ST_MUT_MUL : ST_MUT_WR;
                    else if (op_reg == OP_FIT)
                    begin
                        prod_reg  <= 64'(rd_data_reg) * 64'(w_reg);
                        wprod_reg <= 64'(w_reg) * 64'(fitness_factor_reg);
                        state_reg <= ST_FIT_ACC;
                    end
                    else
                    begin
                        prod_reg  <= 64'(load_prod);
                        state_reg <= ST_LOAD_ACC;
                    end
                end
                ST_MUT_MUL:
                begin
                    prod_reg  <= 64'(old_reg) * 64'(prob_sel);
                    state_reg <= ST_MUT_ACC;
                end
                ST_MUT_ACC:
                begin
                    out_sum_reg     <= out_sum_reg + PW'(amount);
                    pend_reg[j_reg] <= pend_reg[j_reg] + PW'(amount);
                    if (LIMW'(j_reg) + LIMW'(1) < lim)
                    begin
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= ST_MUT_MUL;
                    end
                    else
                        state_reg <= ST_MUT_WR;
                end
                ST_MUT_WR:
                begin
                    // Advance the arrival window by one bin
                    for (int d = 0; d < KERNEL_MAX - 1; d++)
                        pend_reg[d] <= pend_reg[d+1];
                    pend_reg[KERNEL_MAX-1] <= '0;
                    i_reg <= i_reg + AW'(1);
                    state_reg <= last_bin ? ST_IDLE : ST_ISSUE;
                end
                ST_FIT_ACC:
                begin
                    w_reg <= w_next;
                    if (!pass_reg)
                    begin
                        total_reg <= total_next;
                        i_reg     <= i_reg + AW'(1);
                        if (!last_bin)
                            state_reg <= ST_ISSUE;
                        else if (total_next == '0)
                        begin
                            result_valid_reg <= 1'b1;
                            result_kind_reg  <= KIND_TOTAL;
                            result_value_reg <= '0;
                            divide_fault_reg <= 1'b1;
                            state_reg        <= ST_IDLE;
                        end
                        else
                        begin
                            pass_reg  <= 1'b1;
                            w_reg     <= ONE_Q31;
                            i_reg     <= '0;
                            state_reg <= ST_ISSUE;
                        end
                    end
                    else
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.y     <= prod_reg[63:31];
                        state_reg         <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        i_reg <= i_reg + AW'(1);
                        if (last_bin)
                        begin
                            result_valid_reg <= 1'b1;
                            result_kind_reg  <= KIND_TOTAL;
                            result_value_reg <= (64'(total_reg) > 64'(RES_MAX)) ?
                                                RES_MAX : 41'(total_reg);
                            divide_fault_reg <= 1'b0;
                            state_reg        <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_ISSUE;
                    end
                end
                ST_LOAD_ACC:
                begin
                    acc_reg <= acc_reg + LW'(prod_reg);
                    i_reg   <= i_reg + AW'(1);
                    if (last_bin)
                    begin
                        result_valid_reg <= 1'b1;
                        result_kind_reg  <= KIND_LOAD;
                        result_value_reg <= (64'(acc_reg + LW'(prod_reg)) > 64'(RES_MAX)) ?
                                            RES_MAX : 41'(acc_reg + LW'(prod_reg));
                        divide_fault_reg <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_ISSUE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign result_value = result_value_reg;
    assign divide_fault = divide_fault_reg;
endmodule

// File: hw/rtl/msgs_div.sv
// Bit-serial restoring divider: quotient of (y << 31) / divisor, 32 bits.
// Depends on msgs_pkg for the request struct.
`timescale 1ns / 1ps
module msgs_div #(
    parameter int TW = 43
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msgs_pkg::div_req_t   req,
    input  logic [TW-1:0]        divisor,
    output logic                 done,
    output logic [31:0]          quotient
);
    import msgs_pkg::*;

    logic [TW-1:0] rem_reg;
    logic [4:0]    cnt_reg;
    logic          active_reg;
    logic          ybit_reg;
    logic          done_reg;
    logic [31:0]   q_reg;
    logic [TW:0]   trial;
    logic          fits;

    // Only the first step shifts in a dividend bit; all later ones shift in zero
    assign trial = {rem_reg, (cnt_reg == 5'd31) ? ybit_reg : 1'b0};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg    <= TW'(req.y >> 1);
                ybit_reg   <= req.y[0];
                cnt_reg    <= 5'd31;
                active_reg <= 1'b1;
                q_reg      <= '0;
            end
            else if (active_reg)
            begin
                rem_reg <= fits ? TW'(trial - {1'b0, divisor}) : TW'(trial);
                q_reg   <= {q_reg[30:0], fits};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// File: hw/rtl/msgs_check.sv
// Port-level checker for the mutation-selection generation step, with its bind.
// Depends on msgs_pkg and the top level.
`timescale 1ns / 1ps
module msgs_check (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  op,
    input logic        result_valid,
    input logic [1:0]  result_kind,
    input logic [40:0] result_value,
    input logic        divide_fault
);
    import msgs_pkg::*;

    // A read request answers after the store read and the result register
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_READ |-> ##2 result_valid)
        else $error("read result missing");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

    a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && divide_fault |-> result_kind == KIND_TOTAL && result_value == '0)
        else $error("malformed fault result");
endmodule

bind mutation_selection_generation_step msgs_check u_msgs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .result_value (result_value),
    .divide_fault (divide_fault)
);

// File: tb/mutation_selection_generation_step_tb.sv
// Self-checking testbench for the mutation-selection generation step.
// Depends on msgs_pkg and the top level; predicts every result from its own model.
`timescale 1ns / 1ps
module mutation_selection_generation_step_tb;
    import msgs_pkg::*;

    localparam int NBINS = 1024;
    localparam int KMAX = 6;
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam longint CYCLE_LIMIT = 30000000;

    typedef struct {
        logic [1:0]  kind;
        logic [40:0] value;
        logic        fault;
    } bin_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  op = '0;
    logic [9:0]  bin_index = '0;
    logic [31:0] bin_value = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [40:0] result_value;
    logic        divide_fault;

    // Predictor state
    logic [31:0] hist[NBINS];
    logic [2:0]  kern_len;
    logic [31:0] mut_prob[1:5];
    logic [31:0] fit_factor;
    bin_result_t pending_results[$];
    int          error_count = 0;
    longint      cycle_count = 0;
    int          gap_pct = 0;

    mutation_selection_generation_step u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        bin_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d value=%0d", result_kind, result_value);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_kind !== exp_r.kind)
                begin
                    $error("result_kind expected %0d actual %0d", exp_r.kind, result_kind);
                    error_count++;
                end
                if (result_value !== exp_r.value)
                begin
                    $error("result_value expected %0d actual %0d", exp_r.value, result_value);
                    error_count++;
                end
                if (divide_fault !== exp_r.fault)
                begin
                    $error("divide_fault expected %0d actual %0d", exp_r.fault, divide_fault);
                    error_count++;
                end
            end
        end
    end

    function automatic longint unsigned next_weight(longint unsigned w);
        longint unsigned n;
        n = (w * longint'(fit_factor)) >> 31;
        return (n > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : n;
    endfunction

    function automatic logic [40:0] clip41(longint unsigned v);
        return (v > longint'(RES_MAX)) ? RES_MAX : v[40:0];
    endfunction

    function automatic void spread_mutations();
        longint acc[NBINS];
        longint unsigned amt;
        int k;
        int lim;
        k = (kern_len > KMAX) ? KMAX : kern_len;
        for (int i = 0; i < NBINS; i++) acc[i] = hist[i];
        for (int i = 0; i + 1 < NBINS; i++)
        begin
            lim = (k > NBINS - 1 - i) ? NBINS - 1 - i : k;
            for (int j = 1; j < lim; j++)
            begin
                amt = (j <= 5) ? (longint'(hist[i]) * longint'(mut_prob[j])) >> 31 : 0;
                acc[i] -= amt;
                acc[i + j] += amt;
            end
        end
        for (int i = 0; i < NBINS; i++)
            hist[i] = (acc[i] < 0) ? 32'd0 : (acc[i] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                       : acc[i][31:0];
    endfunction

    function automatic bin_result_t select_fitness();
        bin_result_t r;
        longint unsigned w;
        longint unsigned total;
        longint unsigned y;
        w = ONE_Q31;
        total = 0;
        for (int i = 0; i < NBINS; i++)
        begin
            total += (longint'(hist[i]) * w) >> 31;
            w = next_weight(w);
        end
        r.kind = KIND_TOTAL;
        r.value = 0;
        r.fault = 1'b1;
        if (total != 0)
        begin
            w = ONE_Q31;
            for (int i = 0; i < NBINS; i++)
            begin
                y = (longint'(hist[i]) * w) >> 31;
                hist[i] = 32'((y << 31) / total);
                w = next_weight(w);
            end
            r.value = clip41(total);
            r.fault = 1'b0;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted request
    function automatic void predict_request(logic [2:0] o, logic [9:0] idx, logic [31:0] v);
        bin_result_t r;
        longint unsigned s;
        r.fault = 1'b0;
        case (o)
            OP_WRITE: hist[idx] = v;
            OP_MUT: spread_mutations();
            OP_FIT: pending_results = {pending_results, select_fitness()};
            OP_READ:
            begin
                r.kind = KIND_BIN;
                r.value = {9'd0, hist[idx]};
                pending_results = {pending_results, r};
            end
            OP_LOAD:
            begin
                s = 0;
                for (int i = 0; i < NBINS; i++) s += longint'(i) * longint'(hist[i]);
                r.kind = KIND_LOAD;
                r.value = clip41(s);
                pending_results = {pending_results, r};
            end
            default: ;
        endcase
    endfunction

    // Send one request; returns at the accepting edge with start still high
    task automatic send_request(logic [2:0] o, logic [9:0] idx, logic [31:0] v);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        bin_index <= idx;
        bin_value <= v;
        do
            @(posedge clk);
        while (busy);
        predict_request(o, idx, v);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_KERNEL_LEN: kern_len = data[2:0];
            REG_FITNESS: fit_factor = data;
            REG_SPARE: ;
            default: mut_prob[idx] = data;
        endcase
    endtask

    task automatic set_kernel(logic [2:0] klen, logic [31:0] p1, logic [31:0] p2,
                              logic [31:0] p3, logic [31:0] p4, logic [31:0] p5,
                              logic [31:0] ff);
        wait_idle();
        write_register(REG_KERNEL_LEN, {29'd0, klen});
        write_register(REG_PROB_ONE, p1);
        write_register(REG_PROB_TWO, p2);
        write_register(REG_PROB_THREE, p3);
        write_register(REG_PROB_FOUR, p4);
        write_register(REG_PROB_FIVE, p5);
        write_register(REG_FITNESS, ff);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_fraction();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return ONE_Q31;
            2: return $urandom_range(32'h8000_0000);
            default: return $urandom_range(32'h0200_0000);
        endcase
    endfunction

    // Reset state, extremes of the fields and each op, spare codes included
    task automatic test_directed_ops();
        send_request(OP_READ, 10'd0, '0);
        send_request(OP_READ, 10'd1, '0);
        send_request(OP_LOAD, '0, '0);
        send_request(OP_FIT, '0, '0);
        send_request(OP_READ, 10'd0, '0);
        send_request(OP_WRITE, 10'd1023, ONE_Q31);
        send_request(OP_READ, 10'd1023, '0);
        send_request(OP_LOAD, '0, '0);
        send_request(OP_WRITE, 10'd1023, 32'd0);
        send_request(OP_WRITE, 10'd0, ONE_Q31);
        send_request(OP_MUT, '0, '0);
        send_request(OP_SPARE_5, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_SPARE_6, '0, '0);
        send_request(OP_SPARE_7, '0, '0);
        send_request(OP_READ, 10'd0, '0);
    endtask

    // Mutation at full kernel, including the top end of the store, then weighting
    task automatic test_mutation_kernel();
        set_kernel(3'd6, 32'h1000_0000, 32'h0800_0000, 32'h0400_0000, 32'h0200_0000,
                   32'h0100_0000, ONE_Q31);
        send_request(OP_WRITE, 10'd1020, 32'h4000_0000);
        send_request(OP_MUT, '0, '0);
        send_request(OP_READ, 10'd1, '0);
        send_request(OP_READ, 10'd1023, '0);
        send_request(OP_LOAD, '0, '0);
        send_request(OP_FIT, '0, '0);
        send_request(OP_READ, 10'd5, '0);
    endtask

    // Zero weighted total leaves the store alone and flags the fault
    task automatic test_fitness_fault();
        set_kernel(3'd7, ONE_Q31, ONE_Q31, 32'd0, 32'd0, ONE_Q31, 32'd0);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        send_request(OP_WRITE, 10'd0, 32'd0);
        send_request(OP_WRITE, 10'd3, 32'h2000_0000);
        send_request(OP_FIT, '0, '0);
        send_request(OP_READ, 10'd3, '0);
    endtask

    // Random generations: seed a distribution, step, weigh, read back, spare ops mixed in
    task automatic test_random_generations(int n_items);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_request(OP_WRITE, ($urandom_range(3) == 0) ? 10'($urandom)
                             : 10'($urandom_range(12)), rand_fraction());
            else if (r < 80)
                send_request(OP_READ, ($urandom_range(3) == 0) ? 10'($urandom)
                             : 10'($urandom_range(16)), 32'($urandom));
            else if (r < 86)
                send_request(OP_MUT, 10'($urandom), 32'($urandom));
            else if (r < 90)
                send_request(OP_FIT, 10'($urandom), 32'($urandom));
            else if (r < 94)
                send_request(OP_LOAD, 10'($urandom), 32'($urandom));
            else
                send_request(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), 10'($urandom),
                             32'($urandom));
            if (r < 94) sent++;
        end
    endtask

    initial
    begin
        for (int i = 0; i < NBINS; i++) hist[i] = '0;
        hist[0] = ONE_Q31;
        kern_len = 3'd1;
        for (int j = 1; j <= 5; j++) mut_prob[j] = '0;
        fit_factor = FITNESS_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_mutation_kernel();
        test_fitness_fault();

        set_kernel(3'd6, 32'($urandom_range(32'h2000_0000)), 32'($urandom_range(32'h1000_0000)),
                   32'($urandom_range(32'h0800_0000)), 32'($urandom_range(32'h0400_0000)),
                   32'($urandom_range(32'h0200_0000)), 32'($urandom_range(32'h8000_0000)));
        gap_pct = 6;
        test_random_generations(36);
        set_kernel(3'd3, 32'($urandom_range(32'h4000_0000)), 32'($urandom_range(32'h4000_0000)),
                   32'($urandom), 32'($urandom), 32'($urandom), FITNESS_RST);
        gap_pct = 75;
        test_random_generations(36);
        set_kernel(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'($urandom_range(32'h7FFF_FFFF)));
        gap_pct = 0;
        test_random_generations(36);

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
